// ===== sv/bpsp_pkg.sv =====
// Shared types, codes and constants for the bind packet sequence parser.
// No dependencies; imported by every module of the block.
package bpsp_pkg;

	localparam int RecLen   = 26;
	localparam int RecIdxW  = $clog2(RecLen);
	localparam int ProtoPos = 25;
	localparam int SumW     = 11;

	localparam logic [15:0] TimeoutReset = 16'd500;

	localparam logic [7:0] HdrSync = 8'hff;
	localparam logic [7:0] HdrA1   = 8'haa;
	localparam logic [7:0] HdrA2   = 8'h55;
	localparam logic [7:0] HdrB1   = 8'hab;
	localparam logic [7:0] HdrB2   = 8'h56;

	// hop byte placement in the record
	localparam int Hop0Base = 5;
	localparam int Hop1Base = 12;
	localparam int Hop2Base = 19;
	localparam int HopLen   = 7;
	localparam int Hop2Len  = 6;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_PACKET = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	localparam logic [2:0] KIND_IGNORED  = 3'd0;
	localparam logic [2:0] KIND_PROGRESS = 3'd1;
	localparam logic [2:0] KIND_RECORD   = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
	localparam logic [2:0] KIND_STARTED  = 3'd4;

	localparam logic [1:0] STAGE_HEADER = 2'd0;
	localparam logic [1:0] STAGE_HOP0   = 2'd1;
	localparam logic [1:0] STAGE_HOP1   = 2'd2;
	localparam logic [1:0] STAGE_HOP2   = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [7:0] byte5;
		logic [7:0] byte6;
		logic [7:0] byte7;
		logic [7:0] byte8;
		logic [7:0] byte9;
	} in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] bind_stage;
		logic [4:0] byte_index;
		logic [7:0] byte_value;
		logic       last;
	} out_t;

	// command handed from front to back
	typedef struct packed {
		logic       is_record;
		logic [2:0] kind;
		logic [1:0] stage;
	} cmd_t;

	typedef logic [RecLen-1:0][7:0] record_t;

endpackage

// ===== sv/bind_packet_sequence_parser.sv =====
// Top level of the bind packet sequence parser: front, command queue, back.
// Depends on bpsp_pkg, bpsp_front, bpsp_queue and bpsp_back.
//
// A transaction is taken when start is high and busy low. Every transaction
// gives one result (last set), registered through the queue and the back
// end's result register, except a third hop packet that completes the bind:
// that gives 26 record-byte results on consecutive cycles, index 0 to 25,
// last on index 25. Results appear for one cycle on strobe and must be taken
// then; there is no back-pressure. The queue between front and back lets up
// to QueueDepth transactions be taken ahead of the back end, so short
// transactions can follow each other every cycle; busy rises when the queue
// is full and stays high from a completing packet until its 26th record byte
// has gone out, since the record run is read from the same store that the
// next header would overwrite. A completing bind therefore holds off the next
// transaction while the back end steps one record byte a cycle. The register
// bind_timeout_ticks (reset 500) is to be written through cfg_we and cfg_data
// only while idle; the block itself does not enforce this. It is loaded into
// the timer by a start command taken while no bind is active.
module bind_packet_sequence_parser #(
	parameter int QueueDepth = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bpsp_pkg::in_t   item,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_data,
	output logic            strobe,
	output bpsp_pkg::out_t  result
);
	import bpsp_pkg::*;

	logic    push;
	logic    pop;
	logic    q_empty;
	logic    q_full;
	logic    rec_done;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	record_t record;

	// front: classifies each transaction and updates binding state at once
	bpsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.rec_done (rec_done),
		.busy     (busy),
		.push     (push),
		.cmd      (push_cmd),
		.record   (record)
	);

	// commands waiting for the back end
	bpsp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (head_cmd),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back: one result per command, or a 26-byte run for a finished record
	bpsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (head_cmd),
		.record   (record),
		.pop      (pop),
		.strobe   (strobe),
		.result   (result),
		.rec_done (rec_done)
	);

	// record bytes go out in index order without gaps
	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind == KIND_RECORD) && !result.last |=>
		strobe && (result.kind == KIND_RECORD) &&
		(result.byte_index == $past(result.byte_index) + 5'd1))
		else $error("record run broken");

	// a run closes on the protocol id byte
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind == KIND_RECORD) && result.last |->
		(result.byte_index == 5'(RecLen - 1)))
		else $error("record run closed at wrong index");

	// single results always carry last
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind != KIND_RECORD) |-> result.last)
		else $error("single result without last");

	// store must not be overwritten mid-run
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind == KIND_RECORD) && !result.last |-> busy)
		else $error("transaction accepted during record run");

endmodule

// ===== sv/bpsp_queue.sv =====
// Short command queue between front and back of the bind packet parser.
// Depends on bpsp_pkg (cmd_t).
module bpsp_queue #(
	parameter int Depth = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpsp_pkg::cmd_t push_data,
	input  logic           pop,
	output bpsp_pkg::cmd_t pop_data,
	output logic           empty,
	output logic           full
);
	import bpsp_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CntW'(Depth));
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/bpsp_front.sv =====
// Front of the bind packet parser: accepts and classifies transactions,
// holds binding state, timeout register and record store. Depends on bpsp_pkg.
module bpsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bpsp_pkg::in_t     item,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              q_full,
	input  logic              rec_done,
	output logic              busy,
	output logic              push,
	output bpsp_pkg::cmd_t    cmd,
	output bpsp_pkg::record_t record
);
	import bpsp_pkg::*;

	logic [15:0]     timeout_q;
	logic            active_q;
	logic [1:0]      stage_q;
	logic [SumW-1:0] sum_q;
	logic [15:0]     ticks_q;
	logic            pend_q;
	logic [7:0]      rec_q [RecLen];

	logic [7:0]      pkt [10];
	logic            accept;
	logic            active_d;
	logic [1:0]      stage_d;
	logic [SumW-1:0] sum_d;
	logic [15:0]     ticks_d;
	logic [15:0]     tick_dec;
	logic [2:0]      kind_d;
	logic            wr_hdr;
	logic            wr_hop;
	logic            is_rec;
	logic            hdr_ok;
	logic            hop_ok;
	logic [SumW-1:0] hdr_sum;
	logic [1:0]      seq;

	assign pkt[0] = item.byte0;
	assign pkt[1] = item.byte1;
	assign pkt[2] = item.byte2;
	assign pkt[3] = item.byte3;
	assign pkt[4] = item.byte4;
	assign pkt[5] = item.byte5;
	assign pkt[6] = item.byte6;
	assign pkt[7] = item.byte7;
	assign pkt[8] = item.byte8;
	assign pkt[9] = item.byte9;

	// a pending record run holds off the next transaction: the store is in use
	assign busy   = q_full || pend_q;
	assign accept = start && !busy;
	assign push   = accept;

	assign hdr_ok = (pkt[0] == HdrSync) &&
		(((pkt[1] == HdrA1) && (pkt[2] == HdrA2)) ||
		 ((pkt[1] == HdrB1) && (pkt[2] == HdrB2)));
	// five bytes of at most 255 cannot overflow 11 bits
	assign hdr_sum = SumW'(pkt[3]) + SumW'(pkt[4]) + SumW'(pkt[5]) +
		SumW'(pkt[6]) + SumW'(pkt[7]);
	assign seq    = stage_q - STAGE_HOP0;
	assign hop_ok = (pkt[0] == sum_q[7:0]) &&
		(pkt[1] == {5'd0, sum_q[SumW-1:8]}) &&
		(pkt[2] == {6'd0, seq});
	assign tick_dec = (ticks_q != 16'd0) ? ticks_q - 16'd1 : ticks_q;

	always_comb begin
		active_d = active_q;
		stage_d  = stage_q;
		sum_d    = sum_q;
		ticks_d  = ticks_q;
		kind_d   = KIND_IGNORED;
		wr_hdr   = 1'b0;
		wr_hop   = 1'b0;
		is_rec   = 1'b0;
		case (item.mode)
			MODE_START: begin
				if (!active_q) begin
					active_d = 1'b1;
					stage_d  = STAGE_HEADER;
					ticks_d  = timeout_q;
					kind_d   = KIND_STARTED;
				end
			end
			MODE_TICK: begin
				ticks_d = tick_dec;
				if (active_q && (tick_dec == 16'd0)) begin
					active_d = 1'b0;
					stage_d  = STAGE_HEADER;
					kind_d   = KIND_TIMEOUT;
				end
			end
			MODE_PACKET: begin
				if (active_q) begin
					if (ticks_q == 16'd0) begin
						active_d = 1'b0;
						stage_d  = STAGE_HEADER;
						kind_d   = KIND_TIMEOUT;
					end else if (stage_q == STAGE_HEADER) begin
						if (hdr_ok) begin
							wr_hdr  = 1'b1;
							sum_d   = hdr_sum;
							stage_d = STAGE_HOP0;
							kind_d  = KIND_PROGRESS;
						end
					end else if (hop_ok) begin
						wr_hop = 1'b1;
						if (stage_q == STAGE_HOP2) begin
							active_d = 1'b0;
							stage_d  = STAGE_HEADER;
							kind_d   = KIND_RECORD;
							is_rec   = 1'b1;
						end else begin
							stage_d = stage_q + 2'd1;
							kind_d  = KIND_PROGRESS;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd = '{is_record: is_rec, kind: kind_d, stage: stage_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			active_q  <= 1'b0;
			stage_q   <= STAGE_HEADER;
			sum_q     <= '0;
			ticks_q   <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (accept) begin
				active_q <= active_d;
				stage_q  <= stage_d;
				sum_q    <= sum_d;
				ticks_q  <= ticks_d;
			end
			if (accept && is_rec) begin
				pend_q <= 1'b1;
			end else if (rec_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_hdr) begin
			rec_q[ProtoPos] <= pkt[1];
			for (int i = 0; i < 5; i++) begin
				rec_q[i] <= pkt[3+i];
			end
		end
		if (accept && wr_hop) begin
			case (stage_q)
				STAGE_HOP0: begin
					for (int i = 0; i < HopLen; i++) begin
						rec_q[Hop0Base+i] <= pkt[3+i];
					end
				end
				STAGE_HOP1: begin
					for (int i = 0; i < HopLen; i++) begin
						rec_q[Hop1Base+i] <= pkt[3+i];
					end
				end
				STAGE_HOP2: begin
					for (int i = 0; i < Hop2Len; i++) begin
						rec_q[Hop2Base+i] <= pkt[3+i];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < RecLen; i++) begin
			record[i] = rec_q[i];
		end
	end

endmodule

// ===== sv/bpsp_back.sv =====
// Back of the bind packet parser: drains queued commands into result strobes,
// walking the record store for a completed bind. Depends on bpsp_pkg.
module bpsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  bpsp_pkg::cmd_t    head,
	input  bpsp_pkg::record_t record,
	output logic              pop,
	output logic              strobe,
	output bpsp_pkg::out_t    result,
	output logic              rec_done
);
	import bpsp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t             state_q;
	logic [RecIdxW-1:0] cnt_q;
	logic               strobe_q;
	out_t               res_q;
	logic               done_q;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign strobe   = strobe_q;
	assign result   = res_q;
	assign rec_done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (head.is_record) begin
							state_q <= ST_DUMP;
							cnt_q   <= '0;
						end else begin
							strobe_q <= 1'b1;
						end
					end
				end
				ST_DUMP: begin
					strobe_q <= 1'b1;
					if (cnt_q == RecIdxW'(RecLen - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DUMP) begin
			res_q.kind       <= KIND_RECORD;
			res_q.bind_stage <= STAGE_HEADER;
			res_q.byte_index <= 5'(cnt_q);
			res_q.byte_value <= record[cnt_q];
			res_q.last       <= (cnt_q == RecIdxW'(RecLen - 1));
		end else begin
			res_q.kind       <= head.kind;
			res_q.bind_stage <= head.stage;
			res_q.byte_index <= '0;
			res_q.byte_value <= '0;
			res_q.last       <= 1'b1;
		end
	end

endmodule

// ===== test/bpsp_tb_pkg.sv =====
// Scoreboard for the bind packet sequence parser testbench: a bit-accurate
// predictor of the block plus the queue of results it owes.
// Depends on bpsp_pkg for the transaction types, codes and constants.
package bpsp_tb_pkg;

	import bpsp_pkg::*;

	typedef logic [7:0] pkt_bytes_t [10];

	class bind_scoreboard;

		bit          active;
		logic [1:0]  stage;
		logic [SumW-1:0] addr_sum;
		logic [15:0] ticks_left;
		logic [15:0] timeout_ticks;
		logic [7:0]  record [RecLen];

		out_t bind_results_due[$];

		int errors;
		int commands;
		int checked;
		int records_done;
		int timeouts_seen;

		function new();
			timeout_ticks = TimeoutReset;
			active        = 1'b0;
			stage         = STAGE_HEADER;
			addr_sum      = '0;
			ticks_left    = '0;
			foreach (record[i]) record[i] = '0;
		endfunction

		function void set_timeout(logic [15:0] v);
			timeout_ticks = v;
		endfunction

		function int outstanding();
			return bind_results_due.size();
		endfunction

		// single status result, stage as it stands after the step
		function void queue_status(logic [2:0] kind);
			out_t r;
			r.kind       = kind;
			r.bind_stage = stage;
			r.byte_index = '0;
			r.byte_value = '0;
			r.last       = 1'b1;
			bind_results_due.push_back(r);
		endfunction

		function void end_bind();
			active = 1'b0;
			stage  = STAGE_HEADER;
		endfunction

		function bit hop_matches(pkt_bytes_t p, logic [7:0] seq);
			return p[0] == addr_sum[7:0] && p[1] == 8'(addr_sum >> 8) && p[2] == seq;
		endfunction

		function void store_bytes(pkt_bytes_t p, int base, int count);
			for (int i = 0; i < count; i++) record[base + i] = p[3 + i];
		endfunction

		// returns 1 if the packet matched the expected stage
		function bit take_packet(pkt_bytes_t p);
			out_t r;
			case (stage)
				STAGE_HEADER: begin
					if (p[0] != HdrSync ||
					    !((p[1] == HdrA1 && p[2] == HdrA2) || (p[1] == HdrB1 && p[2] == HdrB2)))
						return 1'b0;
					record[ProtoPos] = p[1];
					store_bytes(p, 0, 5);
					addr_sum = '0;
					for (int i = 0; i < 5; i++) addr_sum = addr_sum + SumW'(p[3 + i]);
					stage = STAGE_HOP0;
					queue_status(KIND_PROGRESS);
				end
				STAGE_HOP0: begin
					if (!hop_matches(p, 8'd0)) return 1'b0;
					store_bytes(p, Hop0Base, HopLen);
					stage = STAGE_HOP1;
					queue_status(KIND_PROGRESS);
				end
				STAGE_HOP1: begin
					if (!hop_matches(p, 8'd1)) return 1'b0;
					store_bytes(p, Hop1Base, HopLen);
					stage = STAGE_HOP2;
					queue_status(KIND_PROGRESS);
				end
				default: begin
					if (!hop_matches(p, 8'd2)) return 1'b0;
					store_bytes(p, Hop2Base, Hop2Len);
					end_bind();
					records_done++;
					for (int i = 0; i < RecLen; i++) begin
						r.kind       = KIND_RECORD;
						r.bind_stage = STAGE_HEADER;
						r.byte_index = 5'(i);
						r.byte_value = record[i];
						r.last       = (i == RecLen - 1);
						bind_results_due.push_back(r);
					end
				end
			endcase
			return 1'b1;
		endfunction

		function void note_command(in_t t);
			pkt_bytes_t p;
			p = '{t.byte0, t.byte1, t.byte2, t.byte3, t.byte4,
			      t.byte5, t.byte6, t.byte7, t.byte8, t.byte9};
			commands++;
			case (t.mode)
				MODE_START: begin
					if (active) begin
						queue_status(KIND_IGNORED);
					end else begin
						active     = 1'b1;
						stage      = STAGE_HEADER;
						ticks_left = timeout_ticks;
						queue_status(KIND_STARTED);
					end
				end
				MODE_TICK: begin
					if (ticks_left != 0) ticks_left = ticks_left - 16'd1;
					if (active && ticks_left == 0) begin
						end_bind();
						timeouts_seen++;
						queue_status(KIND_TIMEOUT);
					end else begin
						queue_status(KIND_IGNORED);
					end
				end
				MODE_PACKET: begin
					if (!active) begin
						queue_status(KIND_IGNORED);
					end else if (ticks_left == 0) begin
						end_bind();
						timeouts_seen++;
						queue_status(KIND_TIMEOUT);
					end else if (!take_packet(p)) begin
						queue_status(KIND_IGNORED);
					end
				end
				default: queue_status(KIND_IGNORED);
			endcase
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		task check_result(out_t got);
			out_t  want;
			string diff;
			diff = "";
			if (bind_results_due.size() == 0) begin
				report($sformatf("result with nothing due: kind %0d index %0d value %02h",
					got.kind, got.byte_index, got.byte_value));
				return;
			end
			want = bind_results_due.pop_front();
			checked++;
			if (got.kind !== want.kind)
				diff = {diff, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
			if (got.bind_stage !== want.bind_stage)
				diff = {diff, $sformatf(" stage %0d/%0d", got.bind_stage, want.bind_stage)};
			if (got.byte_index !== want.byte_index)
				diff = {diff, $sformatf(" index %0d/%0d", got.byte_index, want.byte_index)};
			if (got.byte_value !== want.byte_value)
				diff = {diff, $sformatf(" value %02h/%02h", got.byte_value, want.byte_value)};
			if (got.last !== want.last)
				diff = {diff, $sformatf(" last %0b/%0b", got.last, want.last)};
			if (diff != "")
				report({$sformatf("result %0d (got/exp):", checked), diff});
		endtask

	endclass

endpackage

// ===== test/tb_bind_packet_sequence_parser.sv =====
// Top-level testbench for bind_packet_sequence_parser: directed and random
// command streams, checked against the scoreboard in bpsp_tb_pkg.
// Depends on bpsp_pkg, bpsp_tb_pkg and the block's RTL.
module tb_bind_packet_sequence_parser;

	timeunit 1ns;
	timeprecision 1ps;

	import bpsp_pkg::*;
	import bpsp_tb_pkg::*;

	// mode 3 carries no meaning in the block; the package gives it no name
	localparam logic [1:0] ModeUnused = 2'd3;

	// slowest item is a completing bind plus a long sender gap;
	// several times over for about 100 transactions plus config drains
	localparam int unsigned CycleLimit  = 200000;
	localparam int          DrainCycles = 40;
	localparam int          PhaseItems  = 15;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	in_t    item = '0;
	logic   cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic   strobe;
	out_t   result;

	int unsigned cycle_count = 0;
	int          burst_left = 0;

	bind_scoreboard sb = new();

	bind_packet_sequence_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.strobe   (strobe),
		.result   (result)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result monitor: no back-pressure, so every strobe is a result to check.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(result);
	end

	// Watchdog
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("timeout after %0d cycles, %0d results still due",
			cycle_count, sb.outstanding());
		$display("tb_bind_packet_sequence_parser failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Command builders
	// ---------------------------------------------------------------

	// any mode, all ten bytes random
	function automatic in_t random_cmd(logic [1:0] mode);
		logic [95:0] raw;
		in_t t;
		raw    = {$urandom, $urandom, $urandom};
		t      = raw[$bits(in_t)-1:0];
		t.mode = mode;
		return t;
	endfunction

	function automatic in_t packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
	                               logic [7:0] fill);
		in_t t;
		t = '{MODE_PACKET, b0, b1, b2, fill, fill, fill, fill, fill, fill, fill};
		return t;
	endfunction

	// Well-formed packet for whatever stage the predictor says is next:
	// a header with either sync pair, or a hop carrying the running
	// checksum and the right sequence number. Payload bytes random.
	function automatic in_t next_packet();
		in_t t;
		t = random_cmd(MODE_PACKET);
		if (sb.stage == STAGE_HEADER) begin
			t.byte0 = HdrSync;
			if ($urandom_range(0, 1))
				{t.byte1, t.byte2} = {HdrA1, HdrA2};
			else
				{t.byte1, t.byte2} = {HdrB1, HdrB2};
		end else begin
			t.byte0 = sb.addr_sum[7:0];
			t.byte1 = 8'(sb.addr_sum >> 8);
			t.byte2 = 8'(sb.stage) - 8'd1;
		end
		return t;
	endfunction

	// hop with a chosen sequence number and flat payload (directed part)
	function automatic in_t hop_packet(logic [7:0] seq, logic [7:0] fill);
		in_t t;
		t = next_packet();
		t.byte2 = seq;
		{t.byte3, t.byte4, t.byte5, t.byte6, t.byte7, t.byte8, t.byte9} = {7{fill}};
		return t;
	endfunction

	// Random mix: mostly well-formed progress through the stages, with
	// starts, ticks, single-bit damage to the sync/checksum/sequence bytes
	// and pure noise (all four modes) thrown in.
	function automatic in_t pick_random_command();
		in_t         t;
		int          r;
		logic [23:0] head;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			t = random_cmd(MODE_START);
		end else if (r < 72) begin
			t = sb.active ? next_packet() : random_cmd(MODE_START);
		end else if (r < 84) begin
			t = random_cmd(MODE_TICK);
		end else if (r < 92) begin
			t    = next_packet();
			head = {t.byte0, t.byte1, t.byte2} ^ (24'd1 << $urandom_range(0, 23));
			{t.byte0, t.byte1, t.byte2} = head;
		end else begin
			t = random_cmd(2'($urandom_range(0, 3)));
		end
		return t;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones, and now and
	// then a burst with no gaps at all
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(8, 20);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------------------------------------------------------
	// Drivers: inputs change on the falling edge, handshake is sampled
	// on the rising edge.
	// ---------------------------------------------------------------

	task automatic pause_sender(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Present one command and hold it until taken (start high, busy low at
	// a rising edge). Start is left high so a following command can go out
	// on the very next cycle.
	task automatic drive_command(in_t t);
		@(negedge clk);
		start <= 1'b1;
		item  <= t;
		do @(posedge clk); while (busy);
		sb.note_command(t);
	endtask

	task automatic send_with_gap(in_t t);
		pause_sender(pick_gap());
		drive_command(t);
	endtask

	// Stop sending and wait for every owed result. Every command yields at
	// least one result, so an empty queue means the block is idle.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		sb.set_timeout(v);
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	initial begin
		logic [15:0] phase_timeout [5];
		int          phase_count;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, timeout at its reset value.
		// Commands with nothing to act on: packet while idle, tick with the
		// timer already empty, the unused mode.
		send_with_gap(packet(HdrSync, HdrA1, HdrA2, 8'hff));
		send_with_gap(random_cmd(MODE_TICK));
		send_with_gap(random_cmd(ModeUnused));
		// start, then start again while binding (ignored)
		send_with_gap(random_cmd(MODE_START));
		send_with_gap(random_cmd(MODE_START));
		// broken headers: mixed sync pair, wrong first byte
		send_with_gap(packet(HdrSync, HdrA1, HdrB2, 8'h00));
		send_with_gap(packet(8'hfe, HdrA1, HdrA2, 8'h00));
		// header with all-ones address: checksum needs its high byte
		send_with_gap(packet(HdrSync, HdrA1, HdrA2, 8'hff));
		send_with_gap(hop_packet(8'd1, 8'h00));          // wrong sequence
		send_with_gap(hop_packet(8'd0, 8'hff));
		send_with_gap(packet(8'h00, 8'h00, 8'd1, 8'h00)); // wrong checksum
		send_with_gap(random_cmd(MODE_TICK));            // tick mid-bind
		send_with_gap(hop_packet(8'd1, 8'h00));
		send_with_gap(hop_packet(8'd2, 8'ha5));          // full record run
		// second bind, other sync pair, all-zero address
		send_with_gap(random_cmd(MODE_START));
		send_with_gap(packet(HdrSync, HdrB1, HdrB2, 8'h00));
		send_with_gap(hop_packet(8'd0, 8'h00));
		send_with_gap(hop_packet(8'd1, 8'hff));
		send_with_gap(hop_packet(8'd2, 8'hff));
		// shortest timeout: first tick ends the bind
		write_timeout(16'd1);
		send_with_gap(random_cmd(MODE_START));
		send_with_gap(random_cmd(MODE_TICK));
		// timer loaded with zero: a packet times out at once, and so does a
		// tick that finds the timer already empty
		write_timeout(16'd0);
		send_with_gap(random_cmd(MODE_START));
		send_with_gap(packet(HdrSync, HdrA1, HdrA2, 8'h11));
		send_with_gap(random_cmd(MODE_START));
		send_with_gap(random_cmd(MODE_TICK));

		// Random phases over a spread of timeouts: largest, tiny (binds
		// often cut short by ticks), middling, shortest, and a random one.
		phase_timeout = '{16'hffff, 16'($urandom_range(2, 8)), 16'($urandom_range(9, 60)),
		                  16'd1, 16'($urandom_range(61, 65534))};
		foreach (phase_timeout[p]) begin
			write_timeout(phase_timeout[p]);
			phase_count = 0;
			while (phase_count < PhaseItems) begin
				// occasionally let everything drain before the next one
				if ($urandom_range(0, 99) < 4)
					wait_drained();
				send_with_gap(pick_random_command());
				phase_count++;
			end
		end

		// End of run: everything owed must arrive, then a quiet spell long
		// enough for any stray record run to show up.
		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		$display("Summary: %0d commands, %0d results checked, %0d completed binds, %0d timeouts",
			sb.commands, sb.checked, sb.records_done, sb.timeouts_seen);
		$display("Mismatches: %0d", sb.errors);
		if (sb.errors == 0) begin
			$display("tb_bind_packet_sequence_parser passed");
		end else begin
			$display("tb_bind_packet_sequence_parser failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/bpsp_pkg.sv
sv/bpsp_queue.sv
sv/bpsp_front.sv
sv/bpsp_back.sv
sv/bind_packet_sequence_parser.sv
test/bpsp_tb_pkg.sv
test/tb_bind_packet_sequence_parser.sv
